// ----- rtl/core/bcd_pkg.sv -----
// ----------------------------------------------------------------------------
// bcd_pkg
// Types, codes and the bucket hash shared by the block cache directory.
// ----------------------------------------------------------------------------
`default_nettype none

package bcd_pkg;

    localparam int NUM_BUCKETS = 64;
    localparam int BKT_W       = 6;
    localparam int DEV_W       = 16;
    localparam int SEC_W       = 32;
    localparam int STAMP_W     = 32;
    localparam int HOLD_W      = 7;
    localparam int CNT_W       = 7;

    localparam logic [HOLD_W-1:0] HOLDER_MAX   = 7'd127;
    localparam logic [CNT_W-1:0]  RESULT_LIMIT = 7'd64;
    localparam logic [CNT_W-1:0]  PURGE_SAT    = 7'd65;

    // command codes
    localparam logic [2:0] CMD_LOCK_RD    = 3'd0;
    localparam logic [2:0] CMD_LOCK_WR    = 3'd1;
    localparam logic [2:0] CMD_UNLOCK     = 3'd2;
    localparam logic [2:0] CMD_MARK_DIRTY = 3'd3;
    localparam logic [2:0] CMD_FLUSH      = 3'd4;
    localparam logic [2:0] CMD_PURGE      = 3'd5;
    localparam logic [2:0] CMD_FILL_FAIL  = 3'd6;

    // result status codes
    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_NO_SPACE = 3'd2;
    localparam logic [2:0] ST_BUSY     = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    // request kinds
    localparam logic [1:0] REQ_NONE = 2'd0;
    localparam logic [1:0] REQ_FILL = 2'd1;
    localparam logic [1:0] REQ_WB   = 2'd2;

    typedef struct packed {
        logic [2:0]       command;
        logic [DEV_W-1:0] device;
        logic [SEC_W-1:0] sector;
        logic [5:0]       entry_index;
        logic [31:0]      now;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [5:0]       entry_index_res;
        logic [1:0]       request_kind;
        logic [DEV_W-1:0] request_device;
        logic [SEC_W-1:0] request_sector;
        logic             last;
    } res_t;

    // controller to datapath: fixed-width part of the command
    typedef struct packed {
        logic              in_load;
        logic              out_load;
        res_t              out_data;
        logic [BKT_W-1:0]  bk_ra;
        logic [BKT_W-1:0]  bk_wa;
        logic              bk_we;
        logic              nx_we;
        logic              pv_we;
        logic              we_dev;
        logic              we_sec;
        logic              we_stamp;
        logic              we_home;
        logic              we_hold;
        logic              we_dirty;
        logic              we_cached;
        logic              we_stale;
        logic [HOLD_W-1:0] hold_wd;
        logic [BKT_W-1:0]  home_wd;
        logic              dirty_wd;
        logic              cached_wd;
        logic              stale_wd;
    } dp_ctrl_t;

    // datapath to controller: fixed-width part of the status
    typedef struct packed {
        req_t               in;
        logic [BKT_W-1:0]   hash;
        logic               dev_match;
        logic               sec_match;
        logic [DEV_W-1:0]   rd_dev;
        logic [SEC_W-1:0]   rd_sec;
        logic [STAMP_W-1:0] rd_stamp;
        logic [BKT_W-1:0]   rd_home;
        logic [HOLD_W-1:0]  rd_hold;
        logic               rd_dirty;
        logic               rd_cached;
        logic               rd_stale;
        logic               out_free;
    } dp_stat_t;

    function automatic logic [BKT_W-1:0] bucket_of(input logic [DEV_W-1:0] dev,
                                                   input logic [SEC_W-1:0] sec);
        logic [4:0]  mult;
        logic [5:0]  s1;
        logic [10:0] prod;
        case (dev[2:0])
            3'd0:    mult = 5'd3;
            3'd1:    mult = 5'd5;
            3'd2:    mult = 5'd7;
            3'd3:    mult = 5'd11;
            3'd4:    mult = 5'd13;
            3'd5:    mult = 5'd17;
            3'd6:    mult = 5'd19;
            default: mult = 5'd23;
        endcase
        s1   = sec[5:0] + 6'd1;
        prod = 11'(mult) * 11'(s1);
        return prod[BKT_W-1:0];
    endfunction

    function automatic res_t mk_res(input logic [2:0] status, input logic [5:0] idx,
                                    input logic [1:0] kind, input logic [DEV_W-1:0] dev,
                                    input logic [SEC_W-1:0] sec, input logic last);
        res_t r;
        r.status          = status;
        r.entry_index_res = idx;
        r.request_kind    = kind;
        r.request_device  = dev;
        r.request_sector  = sec;
        r.last            = last;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/block_cache_directory_top.sv -----
// ----------------------------------------------------------------------------
// block_cache_directory_top
// Hashed directory of a disk block cache with free list and LRU eviction.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------
//   cmd     | in        | cmd_valid / cmd_stall| bcd_pkg::req_t cmd_data
//   rsp     | out       | rsp_valid / rsp_stall| bcd_pkg::res_t rsp_data
//
// After reset the block runs a clearing pass that rebuilds the free list and
// empties the 64 bucket heads; cmd_stall is high during it. One request is
// worked at a time. A lock hit reads the bucket head and walks the chain
// entry by entry; a miss from the free list then takes the free head and
// links it into the bucket. Eviction, flush and purge scan every bucket and
// each cached entry in its chain, unlinking entries where needed, limited by
// the single read port of the entry memories. A stalled rsp holds the
// sequencer at each result, while the result register lets the next request enter.
//
`default_nettype none

module block_cache_directory_top #(
    parameter int NUM_ENTRIES = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire bcd_pkg::req_t cmd_data,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output bcd_pkg::res_t      rsp_data
);

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int LW = $clog2(NUM_ENTRIES + 1);

    bcd_pkg::dp_ctrl_t ctrl;
    bcd_pkg::dp_stat_t stat;
    logic [IW-1:0]     rd_addr;
    logic [IW-1:0]     ent_wa;
    logic [IW-1:0]     nx_wa;
    logic [LW-1:0]     nx_wd;
    logic [IW-1:0]     pv_wa;
    logic [LW-1:0]     pv_wd;
    logic [LW-1:0]     bk_wd;
    logic [LW-1:0]     rd_next;
    logic [LW-1:0]     rd_prev;
    logic [LW-1:0]     bk_rd;

    // sequencer: walks, scans and list edits
    bcd_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_valid),
        .in_stall (cmd_stall),
        .ctrl     (ctrl),
        .stat     (stat),
        .rd_addr  (rd_addr),
        .ent_wa   (ent_wa),
        .nx_wa    (nx_wa),
        .nx_wd    (nx_wd),
        .pv_wa    (pv_wa),
        .pv_wd    (pv_wd),
        .bk_wd    (bk_wd),
        .rd_next  (rd_next),
        .rd_prev  (rd_prev),
        .bk_rd    (bk_rd)
    );

    // storage, request register and result register
    bcd_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (cmd_data),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_data  (rsp_data),
        .ctrl      (ctrl),
        .stat      (stat),
        .rd_addr   (rd_addr),
        .ent_wa    (ent_wa),
        .nx_wa     (nx_wa),
        .nx_wd     (nx_wd),
        .pv_wa     (pv_wa),
        .pv_wd     (pv_wd),
        .bk_wd     (bk_wd),
        .rd_next   (rd_next),
        .rd_prev   (rd_prev),
        .bk_rd     (bk_rd)
    );

endmodule

`default_nettype wire

// ----- rtl/core/bcd_datapath.sv -----
// ----------------------------------------------------------------------------
// bcd_datapath
// Entry and bucket memories, request register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_datapath #(
    parameter int NUM_ENTRIES = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire bcd_pkg::req_t                        in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output bcd_pkg::res_t                             out_data,
    input  wire bcd_pkg::dp_ctrl_t                    ctrl,
    output bcd_pkg::dp_stat_t                         stat,
    input  wire logic [$clog2(NUM_ENTRIES)-1:0]       rd_addr,
    input  wire logic [$clog2(NUM_ENTRIES)-1:0]       ent_wa,
    input  wire logic [$clog2(NUM_ENTRIES)-1:0]       nx_wa,
    input  wire logic [$clog2(NUM_ENTRIES+1)-1:0]     nx_wd,
    input  wire logic [$clog2(NUM_ENTRIES)-1:0]       pv_wa,
    input  wire logic [$clog2(NUM_ENTRIES+1)-1:0]     pv_wd,
    input  wire logic [$clog2(NUM_ENTRIES+1)-1:0]     bk_wd,
    output logic [$clog2(NUM_ENTRIES+1)-1:0]          rd_next,
    output logic [$clog2(NUM_ENTRIES+1)-1:0]          rd_prev,
    output logic [$clog2(NUM_ENTRIES+1)-1:0]          bk_rd
);

    localparam int LW = $clog2(NUM_ENTRIES + 1);

    logic [bcd_pkg::DEV_W-1:0]   dev_mem    [NUM_ENTRIES];
    logic [bcd_pkg::SEC_W-1:0]   sec_mem    [NUM_ENTRIES];
    logic [bcd_pkg::STAMP_W-1:0] stamp_mem  [NUM_ENTRIES];
    logic [bcd_pkg::BKT_W-1:0]   home_mem   [NUM_ENTRIES];
    logic [bcd_pkg::HOLD_W-1:0]  hold_mem   [NUM_ENTRIES];
    logic                        dirty_mem  [NUM_ENTRIES];
    logic                        cached_mem [NUM_ENTRIES];
    logic                        stale_mem  [NUM_ENTRIES];
    logic [LW-1:0]               next_mem   [NUM_ENTRIES];
    logic [LW-1:0]               prev_mem   [NUM_ENTRIES];
    logic [LW-1:0]               bk_mem     [bcd_pkg::NUM_BUCKETS];

    bcd_pkg::req_t               in_reg;
    bcd_pkg::res_t               out_reg;
    logic                        out_valid_reg;
    logic [bcd_pkg::DEV_W-1:0]   rd_dev_reg;
    logic [bcd_pkg::SEC_W-1:0]   rd_sec_reg;
    logic [bcd_pkg::STAMP_W-1:0] rd_stamp_reg;
    logic [bcd_pkg::BKT_W-1:0]   rd_home_reg;
    logic [bcd_pkg::HOLD_W-1:0]  rd_hold_reg;
    logic                        rd_dirty_reg;
    logic                        rd_cached_reg;
    logic                        rd_stale_reg;
    logic [LW-1:0]               rd_next_reg;
    logic [LW-1:0]               rd_prev_reg;
    logic [LW-1:0]               bk_rd_reg;

    // entry field memories share one write address and one read address
    always_ff @(posedge clk)
    begin
        if (ctrl.we_dev)    dev_mem[ent_wa]    <= in_reg.device;
        if (ctrl.we_sec)    sec_mem[ent_wa]    <= in_reg.sector;
        if (ctrl.we_stamp)  stamp_mem[ent_wa]  <= in_reg.now;
        if (ctrl.we_home)   home_mem[ent_wa]   <= ctrl.home_wd;
        if (ctrl.we_hold)   hold_mem[ent_wa]   <= ctrl.hold_wd;
        if (ctrl.we_dirty)  dirty_mem[ent_wa]  <= ctrl.dirty_wd;
        if (ctrl.we_cached) cached_mem[ent_wa] <= ctrl.cached_wd;
        if (ctrl.we_stale)  stale_mem[ent_wa]  <= ctrl.stale_wd;
        rd_dev_reg    <= dev_mem[rd_addr];
        rd_sec_reg    <= sec_mem[rd_addr];
        rd_stamp_reg  <= stamp_mem[rd_addr];
        rd_home_reg   <= home_mem[rd_addr];
        rd_hold_reg   <= hold_mem[rd_addr];
        rd_dirty_reg  <= dirty_mem[rd_addr];
        rd_cached_reg <= cached_mem[rd_addr];
        rd_stale_reg  <= stale_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.nx_we) next_mem[nx_wa] <= nx_wd;
        rd_next_reg <= next_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.pv_we) prev_mem[pv_wa] <= pv_wd;
        rd_prev_reg <= prev_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.bk_we) bk_mem[ctrl.bk_wa] <= bk_wd;
        bk_rd_reg <= bk_mem[ctrl.bk_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.in_load) in_reg <= in_data;
        if (ctrl.out_load) out_reg <= ctrl.out_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign rd_next   = rd_next_reg;
    assign rd_prev   = rd_prev_reg;
    assign bk_rd     = bk_rd_reg;

    always_comb
    begin
        stat.in        = in_reg;
        stat.hash      = bcd_pkg::bucket_of(in_reg.device, in_reg.sector);
        stat.dev_match = (rd_dev_reg == in_reg.device);
        stat.sec_match = (rd_sec_reg == in_reg.sector);
        stat.rd_dev    = rd_dev_reg;
        stat.rd_sec    = rd_sec_reg;
        stat.rd_stamp  = rd_stamp_reg;
        stat.rd_home   = rd_home_reg;
        stat.rd_hold   = rd_hold_reg;
        stat.rd_dirty  = rd_dirty_reg;
        stat.rd_cached = rd_cached_reg;
        stat.rd_stale  = rd_stale_reg;
        stat.out_free  = !out_valid_reg || !out_stall;
    end

endmodule

`default_nettype wire

// ----- rtl/core/bcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// bcd_ctrl
// Command sequencer: chain walks, bucket scans, list edits and result issue.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_ctrl #(
    parameter int NUM_ENTRIES = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    output bcd_pkg::dp_ctrl_t                         ctrl,
    input  wire bcd_pkg::dp_stat_t                    stat,
    output logic [$clog2(NUM_ENTRIES)-1:0]            rd_addr,
    output logic [$clog2(NUM_ENTRIES)-1:0]            ent_wa,
    output logic [$clog2(NUM_ENTRIES)-1:0]            nx_wa,
    output logic [$clog2(NUM_ENTRIES+1)-1:0]          nx_wd,
    output logic [$clog2(NUM_ENTRIES)-1:0]            pv_wa,
    output logic [$clog2(NUM_ENTRIES+1)-1:0]          pv_wd,
    output logic [$clog2(NUM_ENTRIES+1)-1:0]          bk_wd,
    input  wire logic [$clog2(NUM_ENTRIES+1)-1:0]     rd_next,
    input  wire logic [$clog2(NUM_ENTRIES+1)-1:0]     rd_prev,
    input  wire logic [$clog2(NUM_ENTRIES+1)-1:0]     bk_rd
);

    localparam int IW    = $clog2(NUM_ENTRIES);
    localparam int LW    = $clog2(NUM_ENTRIES + 1);
    localparam int CLR_N = (NUM_ENTRIES > bcd_pkg::NUM_BUCKETS) ? NUM_ENTRIES
                                                               : bcd_pkg::NUM_BUCKETS;
    localparam int CW    = $clog2(CLR_N);
    localparam logic [LW-1:0] NIL = LW'(NUM_ENTRIES);
    localparam logic [bcd_pkg::BKT_W-1:0] LAST_BKT = 6'(bcd_pkg::NUM_BUCKETS - 1);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP, S_LK_HEAD, S_LK_EVAL, S_MISS, S_FP,
        S_IN1, S_IN2, S_IN3, S_SC_B, S_SC_H, S_SC_E, S_SC_NX, S_SC_ADV,
        S_VI_RD, S_RM1, S_RM2, S_EN_EV, S_FIN, S_EMIT
    } state_t;

    typedef enum logic [2:0] {
        M_VICT, M_FLUSH, M_PURGE1, M_PURGE2, M_FAIL
    } mode_t;

    state_t                       state_reg, state_next;
    state_t                       ret_reg, ret_next;
    mode_t                        mode_reg, mode_next;
    logic [CW-1:0]                clr_reg, clr_next;
    logic [bcd_pkg::BKT_W-1:0]    b_reg, b_next;
    logic [bcd_pkg::BKT_W-1:0]    hash_reg, hash_next;
    logic [IW-1:0]                cur_reg, cur_next;
    logic [LW-1:0]                nxt_reg, nxt_next;
    logic [LW-1:0]                p_reg, p_next;
    logic [LW-1:0]                n_reg, n_next;
    logic [bcd_pkg::BKT_W-1:0]    h_reg, h_next;
    logic [LW-1:0]                free_reg, free_next;
    logic [LW-1:0]                bc_reg, bc_next;
    logic [LW-1:0]                bd_reg, bd_next;
    logic [bcd_pkg::STAMP_W-1:0]  bcs_reg, bcs_next;
    logic [bcd_pkg::STAMP_W-1:0]  bds_reg, bds_next;
    logic [bcd_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                         pend_v_reg, pend_v_next;
    bcd_pkg::res_t                pend_reg, pend_next;
    bcd_pkg::res_t                res_reg, res_next;

    logic                         cont;
    logic                         held;
    bcd_pkg::res_t                wb;
    logic [IW-1:0]                idx_e;
    logic [5:0]                   cur6;

    assign in_stall = (state_reg != S_IDLE);
    assign idx_e    = IW'(stat.in.entry_index);
    assign cur6     = 6'(cur_reg);

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        mode_next   = mode_reg;
        clr_next    = clr_reg;
        b_next      = b_reg;
        hash_next   = hash_reg;
        cur_next    = cur_reg;
        nxt_next    = nxt_reg;
        p_next      = p_reg;
        n_next      = n_reg;
        h_next      = h_reg;
        free_next   = free_reg;
        bc_next     = bc_reg;
        bd_next     = bd_reg;
        bcs_next    = bcs_reg;
        bds_next    = bds_reg;
        cnt_next    = cnt_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        res_next    = res_reg;

        ctrl          = '0;
        ctrl.out_data = res_reg;
        ctrl.bk_ra    = b_reg;
        rd_addr       = cur_reg;
        ent_wa        = cur_reg;
        nx_wa         = cur_reg;
        nx_wd         = NIL;
        pv_wa         = cur_reg;
        pv_wd         = NIL;
        bk_wd         = NIL;

        cont = 1'b0;
        held = stat.rd_cached && (stat.rd_hold != '0);
        wb   = bcd_pkg::mk_res(bcd_pkg::ST_DONE, cur6, bcd_pkg::REQ_WB,
                               stat.rd_dev, stat.rd_sec, 1'b0);

        case (state_reg)
            S_CLR:
            begin
                // restore the reset image one row per cycle
                if (int'(clr_reg) < NUM_ENTRIES)
                begin
                    ent_wa         = IW'(clr_reg);
                    ctrl.we_hold   = 1'b1;
                    ctrl.we_dirty  = 1'b1;
                    ctrl.we_cached = 1'b1;
                    ctrl.we_stale  = 1'b1;
                    ctrl.nx_we     = 1'b1;
                    nx_wa          = IW'(clr_reg);
                    nx_wd          = LW'(clr_reg) + LW'(1);
                    ctrl.pv_we     = 1'b1;
                    pv_wa          = IW'(clr_reg);
                end
                if (int'(clr_reg) < bcd_pkg::NUM_BUCKETS)
                begin
                    ctrl.bk_we = 1'b1;
                    ctrl.bk_wa = clr_reg[bcd_pkg::BKT_W-1:0];
                end
                if (clr_reg == CW'(CLR_N - 1))
                    state_next = S_IDLE;
                else
                    clr_next = clr_reg + CW'(1);
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.in_load = 1'b1;
                    state_next   = S_DISP;
                end
            end

            S_DISP:
            begin
                case (stat.in.command)
                    bcd_pkg::CMD_LOCK_RD, bcd_pkg::CMD_LOCK_WR:
                    begin
                        ctrl.bk_ra = stat.hash;
                        hash_next  = stat.hash;
                        state_next = S_LK_HEAD;
                    end
                    bcd_pkg::CMD_UNLOCK, bcd_pkg::CMD_MARK_DIRTY, bcd_pkg::CMD_FILL_FAIL:
                    begin
                        if (int'(stat.in.entry_index) >= NUM_ENTRIES)
                        begin
                            res_next   = bcd_pkg::mk_res(bcd_pkg::ST_BUSY,
                                             stat.in.entry_index, bcd_pkg::REQ_NONE,
                                             '0, '0, 1'b1);
                            ret_next   = S_IDLE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            rd_addr    = idx_e;
                            cur_next   = idx_e;
                            state_next = S_EN_EV;
                        end
                    end
                    bcd_pkg::CMD_FLUSH, bcd_pkg::CMD_PURGE:
                    begin
                        mode_next   = (stat.in.command == bcd_pkg::CMD_FLUSH) ? M_FLUSH
                                                                               : M_PURGE1;
                        b_next      = '0;
                        cnt_next    = '0;
                        pend_v_next = 1'b0;
                        state_next  = S_SC_B;
                    end
                    default:
                    begin
                        res_next   = bcd_pkg::mk_res(bcd_pkg::ST_BUSY, '0,
                                         bcd_pkg::REQ_NONE, '0, '0, 1'b1);
                        ret_next   = S_IDLE;
                        state_next = S_EMIT;
                    end
                endcase
            end

            S_LK_HEAD:
            begin
                if (bk_rd == NIL)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    rd_addr    = IW'(bk_rd);
                    cur_next   = IW'(bk_rd);
                    state_next = S_LK_EVAL;
                end
            end

            S_LK_EVAL:
            begin
                if (!stat.rd_stale && stat.dev_match && stat.sec_match)
                begin
                    if (stat.rd_hold >= bcd_pkg::HOLDER_MAX)
                    begin
                        res_next = bcd_pkg::mk_res(bcd_pkg::ST_BUSY, cur6,
                                       bcd_pkg::REQ_NONE, '0, '0, 1'b1);
                    end
                    else
                    begin
                        ctrl.we_hold = 1'b1;
                        ctrl.hold_wd = stat.rd_hold + 7'd1;
                        res_next     = bcd_pkg::mk_res(bcd_pkg::ST_HIT, cur6,
                                           bcd_pkg::REQ_NONE, '0, '0, 1'b1);
                    end
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else if (rd_next == NIL)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    rd_addr  = IW'(rd_next);
                    cur_next = IW'(rd_next);
                end
            end

            S_MISS:
            begin
                if (free_reg != NIL)
                begin
                    rd_addr    = IW'(free_reg);
                    cur_next   = IW'(free_reg);
                    state_next = S_FP;
                end
                else
                begin
                    mode_next  = M_VICT;
                    b_next     = '0;
                    bc_next    = NIL;
                    bd_next    = NIL;
                    state_next = S_SC_B;
                end
            end

            S_FP:
            begin
                free_next  = rd_next;
                state_next = S_IN1;
            end

            S_IN1:
            begin
                ctrl.bk_ra = hash_reg;
                state_next = S_IN2;
            end

            S_IN2:
            begin
                // link the new entry in front of the bucket chain
                ctrl.nx_we     = 1'b1;
                nx_wd          = bk_rd;
                ctrl.pv_we     = 1'b1;
                ctrl.bk_we     = 1'b1;
                ctrl.bk_wa     = hash_reg;
                bk_wd          = LW'(cur_reg);
                ctrl.we_dev    = 1'b1;
                ctrl.we_sec    = 1'b1;
                ctrl.we_home   = 1'b1;
                ctrl.home_wd   = hash_reg;
                ctrl.we_hold   = 1'b1;
                ctrl.hold_wd   = 7'd1;
                ctrl.we_dirty  = 1'b1;
                ctrl.we_cached = 1'b1;
                ctrl.cached_wd = 1'b1;
                ctrl.we_stale  = 1'b1;
                n_next         = bk_rd;
                state_next     = S_IN3;
            end

            S_IN3:
            begin
                if (n_reg != NIL)
                begin
                    ctrl.pv_we = 1'b1;
                    pv_wa      = IW'(n_reg);
                    pv_wd      = LW'(cur_reg);
                end
                res_next   = bcd_pkg::mk_res(bcd_pkg::ST_MISS, cur6, bcd_pkg::REQ_FILL,
                                 stat.in.device, stat.in.sector, 1'b1);
                ret_next   = S_IDLE;
                state_next = S_EMIT;
            end

            S_SC_B:
            begin
                state_next = S_SC_H;
            end

            S_SC_H:
            begin
                if (bk_rd == NIL)
                begin
                    state_next = S_SC_ADV;
                end
                else
                begin
                    rd_addr    = IW'(bk_rd);
                    cur_next   = IW'(bk_rd);
                    state_next = S_SC_E;
                end
            end

            S_SC_E:
            begin
                nxt_next = rd_next;
                case (mode_reg)
                    M_VICT:
                    begin
                        if (stat.rd_hold == '0)
                        begin
                            if (!stat.rd_dirty)
                            begin
                                if (bc_reg == NIL || stat.rd_stamp < bcs_reg)
                                begin
                                    bc_next  = LW'(cur_reg);
                                    bcs_next = stat.rd_stamp;
                                end
                            end
                            else if (bd_reg == NIL || stat.rd_stamp < bds_reg)
                            begin
                                bd_next  = LW'(cur_reg);
                                bds_next = stat.rd_stamp;
                            end
                        end
                        cont = 1'b1;
                    end
                    M_FLUSH:
                    begin
                        cont = 1'b1;
                        if (stat.rd_dirty && !stat.rd_stale &&
                            cnt_reg < bcd_pkg::RESULT_LIMIT)
                        begin
                            ctrl.we_dirty = 1'b1;
                            cnt_next      = cnt_reg + 7'd1;
                            pend_next     = wb;
                            pend_v_next   = 1'b1;
                            if (pend_v_reg)
                            begin
                                // issue the previous writeback, keep this one
                                res_next   = pend_reg;
                                ret_next   = S_SC_NX;
                                state_next = S_EMIT;
                                cont       = 1'b0;
                            end
                        end
                    end
                    M_PURGE1:
                    begin
                        cont = 1'b1;
                        if (!stat.rd_stale && stat.dev_match)
                        begin
                            if (stat.rd_hold != '0)
                            begin
                                res_next   = bcd_pkg::mk_res(bcd_pkg::ST_BUSY, cur6,
                                                 bcd_pkg::REQ_NONE, '0, '0, 1'b1);
                                ret_next   = S_IDLE;
                                state_next = S_EMIT;
                                cont       = 1'b0;
                            end
                            else if (stat.rd_dirty && cnt_reg != bcd_pkg::PURGE_SAT)
                            begin
                                cnt_next = cnt_reg + 7'd1;
                            end
                        end
                    end
                    M_PURGE2:
                    begin
                        if (!stat.rd_stale && stat.dev_match)
                        begin
                            p_next     = rd_prev;
                            n_next     = rd_next;
                            h_next     = stat.rd_home;
                            state_next = S_RM1;
                            if (stat.rd_dirty && cnt_reg < bcd_pkg::RESULT_LIMIT)
                            begin
                                cnt_next    = cnt_reg + 7'd1;
                                pend_next   = wb;
                                pend_v_next = 1'b1;
                                if (pend_v_reg)
                                begin
                                    res_next   = pend_reg;
                                    ret_next   = S_RM1;
                                    state_next = S_EMIT;
                                end
                            end
                        end
                        else
                        begin
                            cont = 1'b1;
                        end
                    end
                    default:
                    begin
                        cont = 1'b1;
                    end
                endcase
                if (cont)
                begin
                    if (rd_next == NIL)
                    begin
                        state_next = S_SC_ADV;
                    end
                    else
                    begin
                        rd_addr  = IW'(rd_next);
                        cur_next = IW'(rd_next);
                    end
                end
            end

            S_SC_NX:
            begin
                if (nxt_reg == NIL)
                begin
                    state_next = S_SC_ADV;
                end
                else
                begin
                    rd_addr    = IW'(nxt_reg);
                    cur_next   = IW'(nxt_reg);
                    state_next = S_SC_E;
                end
            end

            S_SC_ADV:
            begin
                if (b_reg != LAST_BKT)
                begin
                    b_next     = b_reg + 6'd1;
                    state_next = S_SC_B;
                end
                else
                begin
                    case (mode_reg)
                        M_VICT:
                        begin
                            if (bc_reg != NIL || bd_reg != NIL)
                            begin
                                rd_addr    = (bc_reg != NIL) ? IW'(bc_reg) : IW'(bd_reg);
                                cur_next   = (bc_reg != NIL) ? IW'(bc_reg) : IW'(bd_reg);
                                state_next = S_VI_RD;
                            end
                            else
                            begin
                                res_next   = bcd_pkg::mk_res(bcd_pkg::ST_NO_SPACE, '0,
                                                 bcd_pkg::REQ_NONE, '0, '0, 1'b1);
                                ret_next   = S_IDLE;
                                state_next = S_EMIT;
                            end
                        end
                        M_PURGE1:
                        begin
                            if (cnt_reg > bcd_pkg::RESULT_LIMIT)
                            begin
                                res_next   = bcd_pkg::mk_res(bcd_pkg::ST_BUSY, '0,
                                                 bcd_pkg::REQ_NONE, '0, '0, 1'b1);
                                ret_next   = S_IDLE;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                mode_next   = M_PURGE2;
                                b_next      = '0;
                                cnt_next    = '0;
                                pend_v_next = 1'b0;
                                state_next  = S_SC_B;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_VI_RD:
            begin
                p_next     = rd_prev;
                n_next     = rd_next;
                h_next     = stat.rd_home;
                state_next = S_RM1;
                if (stat.rd_dirty)
                begin
                    res_next   = wb;
                    ret_next   = S_RM1;
                    state_next = S_EMIT;
                end
            end

            S_RM1:
            begin
                // unlink from the chain
                if (p_reg != NIL)
                begin
                    ctrl.nx_we = 1'b1;
                    nx_wa      = IW'(p_reg);
                    nx_wd      = n_reg;
                end
                else
                begin
                    ctrl.bk_we = 1'b1;
                    ctrl.bk_wa = h_reg;
                    bk_wd      = n_reg;
                end
                if (n_reg != NIL)
                begin
                    ctrl.pv_we = 1'b1;
                    pv_wa      = IW'(n_reg);
                    pv_wd      = p_reg;
                end
                ctrl.we_dirty  = 1'b1;
                ctrl.we_cached = 1'b1;
                state_next     = (mode_reg == M_VICT) ? S_IN1 : S_RM2;
            end

            S_RM2:
            begin
                // push onto the free list
                ctrl.nx_we = 1'b1;
                nx_wd      = free_reg;
                ctrl.pv_we = 1'b1;
                free_next  = LW'(cur_reg);
                if (mode_reg == M_PURGE2)
                begin
                    state_next = S_SC_NX;
                end
                else
                begin
                    res_next   = bcd_pkg::mk_res(bcd_pkg::ST_DONE, stat.in.entry_index,
                                     bcd_pkg::REQ_NONE, '0, '0, 1'b1);
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
            end

            S_EN_EV:
            begin
                res_next   = bcd_pkg::mk_res(bcd_pkg::ST_DONE, stat.in.entry_index,
                                 bcd_pkg::REQ_NONE, '0, '0, 1'b1);
                ret_next   = S_IDLE;
                state_next = S_EMIT;
                if (!held || (stat.in.command != bcd_pkg::CMD_UNLOCK && stat.rd_stale))
                begin
                    res_next.status = bcd_pkg::ST_BUSY;
                end
                else
                begin
                    case (stat.in.command)
                        bcd_pkg::CMD_UNLOCK:
                        begin
                            ctrl.we_hold  = 1'b1;
                            ctrl.hold_wd  = stat.rd_hold - 7'd1;
                            ctrl.we_stamp = 1'b1;
                        end
                        bcd_pkg::CMD_MARK_DIRTY:
                        begin
                            ctrl.we_dirty = 1'b1;
                            ctrl.dirty_wd = 1'b1;
                        end
                        default:
                        begin
                            ctrl.we_stale = 1'b1;
                            ctrl.stale_wd = 1'b1;
                            ctrl.we_dirty = 1'b1;
                            ctrl.we_hold  = 1'b1;
                            ctrl.hold_wd  = stat.rd_hold - 7'd1;
                            if (stat.rd_hold == 7'd1)
                            begin
                                p_next     = rd_prev;
                                n_next     = rd_next;
                                h_next     = stat.rd_home;
                                mode_next  = M_FAIL;
                                state_next = S_RM1;
                            end
                        end
                    endcase
                end
            end

            S_FIN:
            begin
                if (pend_v_reg)
                begin
                    res_next      = pend_reg;
                    res_next.last = 1'b1;
                end
                else
                begin
                    res_next = bcd_pkg::mk_res(bcd_pkg::ST_DONE, '0, bcd_pkg::REQ_NONE,
                                   '0, '0, 1'b1);
                end
                ret_next   = S_IDLE;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ret_reg;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            ret_reg    <= S_IDLE;
            mode_reg   <= M_VICT;
            clr_reg    <= '0;
            free_reg   <= '0;
            pend_v_reg <= 1'b0;
            cnt_reg    <= '0;
            b_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            mode_reg   <= mode_next;
            clr_reg    <= clr_next;
            free_reg   <= free_next;
            pend_v_reg <= pend_v_next;
            cnt_reg    <= cnt_next;
            b_reg      <= b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        cur_reg  <= cur_next;
        nxt_reg  <= nxt_next;
        p_reg    <= p_next;
        n_reg    <= n_next;
        h_reg    <= h_next;
        bc_reg   <= bc_next;
        bd_reg   <= bd_next;
        bcs_reg  <= bcs_next;
        bds_reg  <= bds_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire
